@@ src/mrir_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the Modbus read-input-registers framer.
// Used by mrir_beat_out and modbus_read_input_regs_framer; depends on nothing else.
package mrir_pkg;

  // Largest register count a request may ask for.
  localparam int unsigned MAX_WORDS = 125;

  // Modbus function codes.
  localparam logic [7:0] FN_READ_INPUT = 8'h04;
  localparam logic [7:0] FN_EXCEPTION  = 8'h84;

  // CRC-16 polynomial (reflected) and seed.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Output and input stream data widths.
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned IN_TDATA_W  = 48;

  // Request beat index of the last byte and of the CRC low byte.
  localparam logic [2:0] REQ_LAST_BEAT = 3'd7;
  localparam logic [2:0] REQ_CRC_LO    = 3'd6;

  // Kind of a result beat.
  typedef enum logic [1:0] {
    KIND_REQ  = 2'd0,
    KIND_WORD = 2'd1,
    KIND_STAT = 2'd2
  } kind_e;

  // Transaction status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_ADDR      = 3'd2,
    ST_EXCEPTION = 3'd3,
    ST_FUNCTION  = 3'd4,
    ST_BYTECOUNT = 3'd5,
    ST_CRC       = 3'd6,
    ST_BADCOUNT  = 3'd7
  } status_e;

  // The group of results caused by one accepted input beat.
  typedef struct packed {
    logic        req;        // eight request bytes
    logic        bad;        // single bad-count status
    logic        word;       // one register word
    logic        stat;       // transaction status, after the word if both
    logic [7:0]  addr;
    logic [15:0] start_reg;
    logic [15:0] reg_count;
    logic [15:0] word_data;
    logic [6:0]  word_idx;
    status_e     status;
  } batch_t;

  // One byte through the reflected CRC-16, bit by bit.
  function automatic logic [15:0] crc_feed(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

@@ src/mrir_beat_out.sv @@
// Result stage of the framer: holds one batch of results and sends it beat by beat.
// Computes the request CRC one byte per beat. Depends on mrir_pkg.
module mrir_beat_out import mrir_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  batch_t                 batch_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: out_data[15:0], word_index[22:16], status[25:23], zeros above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: out_kind[1:0]
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  logic        valid_q, valid_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  batch_t      batch_q;

  logic        fire;
  logic        last_beat;
  logic [7:0]  req_byte;
  kind_e       kind;
  logic [15:0] data;
  logic [6:0]  idx;
  status_e     st;

  assign fire = valid_q && m_axis_tready_i;

  // Request byte for the current beat.
  always_comb begin
    case (cnt_q)
      3'd0:    req_byte = batch_q.addr;
      3'd1:    req_byte = FN_READ_INPUT;
      3'd2:    req_byte = batch_q.start_reg[15:8];
      3'd3:    req_byte = batch_q.start_reg[7:0];
      3'd4:    req_byte = batch_q.reg_count[15:8];
      3'd5:    req_byte = batch_q.reg_count[7:0];
      3'd6:    req_byte = crc_q[7:0];
      default: req_byte = crc_q[15:8];
    endcase
  end

  // Field selection for the current beat.
  always_comb begin
    kind      = KIND_STAT;
    data      = 16'h0000;
    idx       = 7'd0;
    st        = ST_OK;
    last_beat = 1'b1;
    if (batch_q.req) begin
      kind      = KIND_REQ;
      data      = {8'h00, req_byte};
      last_beat = (cnt_q == REQ_LAST_BEAT);
    end else if (batch_q.bad) begin
      st = ST_BADCOUNT;
    end else if (batch_q.word && (cnt_q == 3'd0)) begin
      kind      = KIND_WORD;
      data      = batch_q.word_data;
      idx       = batch_q.word_idx;
      last_beat = !batch_q.stat;
    end else begin
      st = batch_q.status;
    end
  end

  assign free_o          = !valid_q || (m_axis_tready_i && last_beat);
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {6'd0, st, idx, data};
  assign m_axis_tuser_o  = kind;
  assign m_axis_tlast_o  = last_beat;

  // Beat counter, occupancy and request CRC.
  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    if (fire) begin
      if (last_beat) begin
        valid_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 3'd1;
      end
      if (batch_q.req && (cnt_q < REQ_CRC_LO)) begin
        crc_d = crc_feed(crc_q, req_byte);
      end
    end
    if (load_i) begin
      valid_d = batch_i.req || batch_i.bad || batch_i.word || batch_i.stat;
      cnt_d   = 3'd0;
      crc_d   = CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
      crc_q   <= CRC_INIT;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
    end
  end

  // Batch payload.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      batch_q <= batch_i;
    end
  end

endmodule

@@ src/modbus_read_input_regs_framer.sv @@
// Modbus RTU read-input-registers master framer with CRC-16 request build and response check.
// The first result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: an input beat is taken when the result stage is empty or as the last result beat
// of the one before leaves; a request holds the input until its eight beats leave, a response byte
// until its one or two do; bytes with no or one result flow at one per cycle while not stalled.
// Reset clears the pending transaction and the result stage; the CRC seed is all ones.
// Depends on mrir_pkg and mrir_beat_out.
module modbus_read_input_regs_framer import mrir_pkg::*; #(
  parameter int unsigned MaxWords = MAX_WORDS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: device_addr[7:0], start_reg[23:8], reg_count[39:24], rx_byte[47:40]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: mode[0]
  input  logic                   s_axis_tuser_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: out_data[15:0], word_index[22:16], status[25:23], zeros above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: out_kind[1:0]
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  // Response tracking state.
  logic        pending_q, pending_d;
  logic [7:0]  want_addr_q, want_addr_d;
  logic [6:0]  want_count_q, want_count_d;
  logic [7:0]  byte_pos_q, byte_pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] tail_q, tail_d;
  logic [7:0]  hold_q, hold_d;
  status_e     err_q, err_d;
  logic [6:0]  words_q, words_d;

  logic        free;
  logic        s_fire;
  batch_t      batch;

  logic [7:0]  addr;
  logic [15:0] start_reg;
  logic [15:0] reg_count;
  logic [7:0]  rx_byte;
  logic [8:0]  pos9;
  logic [8:0]  dlen9;
  logic [8:0]  total9;

  assign addr      = s_axis_tdata_i[7:0];
  assign start_reg = s_axis_tdata_i[23:8];
  assign reg_count = s_axis_tdata_i[39:24];
  assign rx_byte   = s_axis_tdata_i[47:40];

  assign s_axis_tready_o = free;
  assign s_fire          = s_axis_tvalid_i && free;

  assign pos9   = {1'b0, byte_pos_q};
  assign dlen9  = {1'b0, want_count_q, 1'b0};
  assign total9 = 9'd5 + dlen9;

  // Request start and response byte checking.
  always_comb begin
    pending_d    = pending_q;
    want_addr_d  = want_addr_q;
    want_count_d = want_count_q;
    byte_pos_d   = byte_pos_q;
    crc_d        = crc_q;
    tail_d       = tail_q;
    hold_d       = hold_q;
    err_d        = err_q;
    words_d      = words_q;

    batch           = '0;
    batch.addr      = addr;
    batch.start_reg = start_reg;
    batch.reg_count = reg_count;
    batch.word_data = {hold_q, rx_byte};
    batch.word_idx  = words_q;
    batch.status    = ST_OK;

    if (!s_axis_tuser_i) begin
      if ((reg_count == 16'd0) || (reg_count > 16'(MaxWords))) begin
        pending_d = 1'b0;
        batch.bad = 1'b1;
      end else begin
        batch.req    = 1'b1;
        pending_d    = 1'b1;
        want_addr_d  = addr;
        want_count_d = reg_count[6:0];
        byte_pos_d   = 8'd0;
        crc_d        = CRC_INIT;
        tail_d       = 16'h0000;
        hold_d       = 8'h00;
        err_d        = ST_OK;
        words_d      = 7'd0;
      end
    end else if (pending_q) begin
      // Header checks; the first fault in byte order wins.
      if (err_q == ST_OK) begin
        if ((byte_pos_q == 8'd0) && (rx_byte != want_addr_q)) begin
          err_d = ST_ADDR;
        end else if ((byte_pos_q == 8'd1) && (rx_byte == FN_EXCEPTION)) begin
          err_d = ST_EXCEPTION;
        end else if ((byte_pos_q == 8'd1) && (rx_byte != FN_READ_INPUT)) begin
          err_d = ST_FUNCTION;
        end else if ((byte_pos_q == 8'd2) && (rx_byte != dlen9[7:0])) begin
          err_d = ST_BYTECOUNT;
        end
      end

      // Payload bytes feed the CRC; the last two bytes are the received CRC.
      if ((pos9 + 9'd2) < total9) begin
        crc_d = crc_feed(crc_q, rx_byte);
      end else if ((pos9 + 9'd2) == total9) begin
        tail_d = {8'h00, rx_byte};
      end else begin
        tail_d = tail_q | {rx_byte, 8'h00};
      end

      // Register words: high byte at odd positions, word out on the low byte.
      if ((pos9 >= 9'd3) && (pos9 < (9'd3 + dlen9))) begin
        if (byte_pos_q[0]) begin
          hold_d = rx_byte;
        end else begin
          batch.word = 1'b1;
          words_d    = words_q + 7'd1;
        end
      end

      byte_pos_d = byte_pos_q + 8'd1;

      // Frame end: explicit marker or expected length reached.
      if (s_axis_tlast_i || ((pos9 + 9'd1) >= total9)) begin
        batch.stat = 1'b1;
        pending_d  = 1'b0;
        if ((pos9 + 9'd1) < 9'd5) begin
          batch.status = ST_SHORT;
        end else if (err_d != ST_OK) begin
          batch.status = err_d;
        end else if ((pos9 + 9'd1) < total9) begin
          batch.status = ST_SHORT;
        end else if (crc_d != tail_d) begin
          batch.status = ST_CRC;
        end else begin
          batch.status = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= 1'b0;
      want_addr_q  <= 8'h00;
      want_count_q <= 7'd0;
      byte_pos_q   <= 8'd0;
      crc_q        <= CRC_INIT;
      tail_q       <= 16'h0000;
      hold_q       <= 8'h00;
      err_q        <= ST_OK;
      words_q      <= 7'd0;
    end else if (s_fire) begin
      pending_q    <= pending_d;
      want_addr_q  <= want_addr_d;
      want_count_q <= want_count_d;
      byte_pos_q   <= byte_pos_d;
      crc_q        <= crc_d;
      tail_q       <= tail_d;
      hold_q       <= hold_d;
      err_q        <= err_d;
      words_q      <= words_d;
    end
  end

  // Result stage.
  mrir_beat_out u_beat_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s_fire),
    .batch_i         (batch),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
